// ===== sv/assert_macros.svh =====
// Assertion macros used by the checker file of the double-ended queue.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property at every rising clock edge outside reset.
`define DEQ_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("deque assertion failed");

// Checks a property at every rising clock edge, reset included.
`define DEQ_ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) \
    else $error("deque assertion failed during or after reset");

`endif

// ===== sv/deq_pkg.sv =====
// Types, constants and helper functions of the double-ended queue.
`timescale 1ns / 1ps
package deq_pkg;

  localparam int DEPTH     = 1024;
  localparam int WORD_BITS = 32;

  localparam int OUT_W   = 32;
  localparam int POS_W   = 10;
  localparam int COUNT_W = 11;

  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CMP_W  = (POS_W > CNT_W) ? POS_W : CNT_W;
  localparam int SUM_W  = CMP_W + 1;

  typedef enum logic [2:0] {
    KIND_PUSH_HEAD = 3'd0,
    KIND_PUSH_TAIL = 3'd1,
    KIND_POP_HEAD  = 3'd2,
    KIND_POP_TAIL  = 3'd3,
    KIND_CLEAR     = 3'd4,
    KIND_READ      = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_POP_EMPTY = 2'd1,
    STATUS_PUSH_FULL = 2'd2,
    STATUS_RANGE     = 2'd3
  } status_e;

  typedef struct packed {
    logic                 we;
    logic [ADDR_W-1:0]    waddr;
    logic [WORD_BITS-1:0] wdata;
    logic [ADDR_W-1:0]    raddr_a;
    logic [ADDR_W-1:0]    raddr_b;
  } mem_req_t;

  typedef struct packed {
    logic                 is_read;
    logic                 empty;
    status_e              status;
    logic [CNT_W-1:0]     count;
    logic                 fwd_a;
    logic                 fwd_b;
    logic [WORD_BITS-1:0] wdata;
  } res_ctrl_t;

  // Reduces a sum below twice the depth to a slot number.
  function automatic logic [ADDR_W-1:0] wrap_slot(logic [SUM_W-1:0] sum);
    if (sum >= SUM_W'(DEPTH)) begin
      return ADDR_W'(sum - SUM_W'(DEPTH));
    end
    return ADDR_W'(sum);
  endfunction

endpackage

// ===== sv/deq_store.sv =====
// Element memory with one write port and two registered read ports.
`timescale 1ns / 1ps
module deq_store (
  input  logic                          clk_i,
  input  logic                          re_i,
  input  deq_pkg::mem_req_t             req_i,
  output logic [deq_pkg::WORD_BITS-1:0] rdata_a_o,
  output logic [deq_pkg::WORD_BITS-1:0] rdata_b_o
);

  logic [deq_pkg::WORD_BITS-1:0] mem [deq_pkg::DEPTH];

  always_ff @(posedge clk_i) begin
    if (req_i.we) begin
      mem[req_i.waddr] <= req_i.wdata;
    end
  end

  // Read data holds while no operation is taken, so a stalled result keeps it.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[req_i.raddr_a];
      rdata_b_o <= mem[req_i.raddr_b];
    end
  end

endmodule

// ===== sv/deq_ctrl.sv =====
// Head and count registers, operation decode and memory addressing.
`timescale 1ns / 1ps
module deq_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      accept_i,
  input  logic [2:0]                kind_i,
  input  logic signed [31:0]        value_i,
  input  logic [deq_pkg::POS_W-1:0] position_i,
  output deq_pkg::mem_req_t         mem_req_o,
  output deq_pkg::res_ctrl_t        res_ctrl_o
);

  logic [deq_pkg::ADDR_W-1:0]    head_q, head_d;
  logic [deq_pkg::CNT_W-1:0]     count_q, count_d;
  logic [deq_pkg::ADDR_W-1:0]    head_dec, head_inc, tail_ins, read_slot, tail_slot;
  logic [deq_pkg::ADDR_W-1:0]    waddr;
  logic [deq_pkg::WORD_BITS-1:0] word;
  logic                          full, empty, we, pos_bad;
  deq_pkg::status_e              status;

  assign word  = deq_pkg::WORD_BITS'(value_i);
  assign full  = (count_q == deq_pkg::CNT_W'(deq_pkg::DEPTH));
  assign empty = (count_q == '0);

  assign head_dec  = (head_q == '0) ? deq_pkg::ADDR_W'(deq_pkg::DEPTH - 1)
                                    : head_q - deq_pkg::ADDR_W'(1);
  assign head_inc  = deq_pkg::wrap_slot(deq_pkg::SUM_W'(head_q) + deq_pkg::SUM_W'(1));
  assign tail_ins  = deq_pkg::wrap_slot(deq_pkg::SUM_W'(head_q) + deq_pkg::SUM_W'(count_q));
  assign read_slot = deq_pkg::wrap_slot(deq_pkg::SUM_W'(head_q) + deq_pkg::SUM_W'(position_i));
  assign pos_bad   = (deq_pkg::CMP_W'(position_i) >= deq_pkg::CMP_W'(count_q));

  always_comb begin
    head_d  = head_q;
    count_d = count_q;
    we      = 1'b0;
    status  = deq_pkg::STATUS_OK;
    waddr   = tail_ins;
    case (deq_pkg::kind_e'(kind_i))
      deq_pkg::KIND_PUSH_HEAD: begin
        if (full) begin
          status = deq_pkg::STATUS_PUSH_FULL;
        end else begin
          head_d  = head_dec;
          count_d = count_q + deq_pkg::CNT_W'(1);
          we      = 1'b1;
          waddr   = head_dec;
        end
      end
      deq_pkg::KIND_PUSH_TAIL: begin
        if (full) begin
          status = deq_pkg::STATUS_PUSH_FULL;
        end else begin
          count_d = count_q + deq_pkg::CNT_W'(1);
          we      = 1'b1;
        end
      end
      deq_pkg::KIND_POP_HEAD: begin
        if (empty) begin
          status = deq_pkg::STATUS_POP_EMPTY;
        end else begin
          head_d  = head_inc;
          count_d = count_q - deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::KIND_POP_TAIL: begin
        if (empty) begin
          status = deq_pkg::STATUS_POP_EMPTY;
        end else begin
          count_d = count_q - deq_pkg::CNT_W'(1);
        end
      end
      deq_pkg::KIND_CLEAR: begin
        head_d  = '0;
        count_d = '0;
      end
      deq_pkg::KIND_READ: begin
        if (pos_bad) begin
          status = deq_pkg::STATUS_RANGE;
        end
      end
      default: begin
      end
    endcase
    if (!accept_i) begin
      head_d  = head_q;
      count_d = count_q;
      we      = 1'b0;
    end
  end

  // The tail slot only matters when the queue is not empty afterward.
  assign tail_slot = deq_pkg::wrap_slot(deq_pkg::SUM_W'(head_d)
                                        + deq_pkg::SUM_W'(count_d - deq_pkg::CNT_W'(1)));

  assign mem_req_o.we      = we;
  assign mem_req_o.waddr   = waddr;
  assign mem_req_o.wdata   = word;
  assign mem_req_o.raddr_a = (kind_i == deq_pkg::KIND_READ) ? read_slot : head_d;
  assign mem_req_o.raddr_b = tail_slot;

  assign res_ctrl_o.is_read = (kind_i == deq_pkg::KIND_READ);
  assign res_ctrl_o.empty   = (count_d == '0);
  assign res_ctrl_o.status  = status;
  assign res_ctrl_o.count   = count_d;
  assign res_ctrl_o.fwd_a   = we && (mem_req_o.raddr_a == waddr);
  assign res_ctrl_o.fwd_b   = we && (tail_slot == waddr);
  assign res_ctrl_o.wdata   = word;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
    end else begin
      head_q  <= head_d;
      count_q <= count_d;
    end
  end

endmodule

// ===== sv/deq_result.sv =====
// Result stage: forwards fresh writes, caches the ends and holds the output register.
`timescale 1ns / 1ps
module deq_result (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          accept_i,
  input  deq_pkg::res_ctrl_t            res_ctrl_i,
  input  logic [deq_pkg::WORD_BITS-1:0] rdata_a_i,
  input  logic [deq_pkg::WORD_BITS-1:0] rdata_b_i,
  input  logic                          out_stall_i,
  output logic                          in_stall_o,
  output logic                          out_valid_o,
  output logic signed [31:0]            front_value_o,
  output logic signed [31:0]            rear_value_o,
  output logic [deq_pkg::COUNT_W-1:0]   count_o,
  output logic signed [31:0]            read_value_o,
  output logic [1:0]                    status_o
);

  deq_pkg::res_ctrl_t            s1_q;
  logic                          s1_valid_q, s1_valid_d;
  logic                          out_valid_q, out_valid_d, s1_adv;
  logic [deq_pkg::WORD_BITS-1:0] word_a, word_b;
  logic [deq_pkg::OUT_W-1:0]     front_c, rear_c, read_c;
  logic [deq_pkg::OUT_W-1:0]     front_cache_q, rear_cache_q;
  logic [deq_pkg::OUT_W-1:0]     front_q, rear_q, read_q;
  logic [deq_pkg::COUNT_W-1:0]   count_q;
  logic [1:0]                    status_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = s1_valid_q && !s1_adv;

  assign word_a = s1_q.fwd_a ? s1_q.wdata : rdata_a_i;
  assign word_b = s1_q.fwd_b ? s1_q.wdata : rdata_b_i;

  always_comb begin
    read_c = '0;
    if (s1_q.is_read) begin
      front_c = front_cache_q;
      rear_c  = rear_cache_q;
      if (s1_q.status == deq_pkg::STATUS_OK) begin
        read_c = deq_pkg::OUT_W'(word_a);
      end
    end else if (s1_q.empty) begin
      front_c = '0;
      rear_c  = '0;
    end else begin
      front_c = deq_pkg::OUT_W'(word_a);
      rear_c  = deq_pkg::OUT_W'(word_b);
    end
  end

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (accept_i) begin
      s1_valid_d = 1'b1;
    end else if (s1_adv) begin
      s1_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q && out_stall_i;
    if (s1_adv) begin
      out_valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q    <= 1'b0;
      out_valid_q   <= 1'b0;
      front_cache_q <= '0;
      rear_cache_q  <= '0;
    end else begin
      s1_valid_q  <= s1_valid_d;
      out_valid_q <= out_valid_d;
      if (s1_adv) begin
        front_cache_q <= front_c;
        rear_cache_q  <= rear_c;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept_i) begin
      s1_q <= res_ctrl_i;
    end
    if (s1_adv) begin
      front_q  <= front_c;
      rear_q   <= rear_c;
      read_q   <= read_c;
      count_q  <= deq_pkg::COUNT_W'(s1_q.count);
      status_q <= s1_q.status;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign front_value_o = front_q;
  assign rear_value_o  = rear_q;
  assign read_value_o  = read_q;
  assign count_o       = count_q;
  assign status_o      = status_q;

endmodule

// ===== sv/double_ended_queue.sv =====
// Top level of the bounded double-ended queue of signed words.
`timescale 1ns / 1ps
// The double-ended queue takes one operation per transfer (push at head, push at tail,
// pop head, pop tail, clear, or read at a position counted from the head) and returns
// exactly one result transfer per operation with the head and tail words after the
// operation (zero when empty), the element count, the word read and a status code.
// It sustains one operation per clock cycle while the output is not stalled. Taking an
// operation updates the head and count registers, writes the element memory, launches
// both memory reads and loads the result stage register; the result is then assembled
// and loaded into the output register once it is free. That stage exists because the
// memory's read ports are registered; the memory reads the head and tail slots (or the
// requested slot) of every operation. The input stalls only while a finished result
// waits in the output register and the following one waits behind it. The memory needs
// no clearing after reset; only words of occupied slots are ever used, and a word
// written by the same operation is forwarded around the memory.
module double_ended_queue (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic [2:0]                  kind_i,
  input  logic signed [31:0]          value_i,
  input  logic [deq_pkg::POS_W-1:0]   position_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic signed [31:0]          front_value_o,
  output logic signed [31:0]          rear_value_o,
  output logic [deq_pkg::COUNT_W-1:0] count_o,
  output logic signed [31:0]          read_value_o,
  output logic [1:0]                  status_o
);

  logic                          accept;
  deq_pkg::mem_req_t             mem_req;
  deq_pkg::res_ctrl_t            res_ctrl;
  logic [deq_pkg::WORD_BITS-1:0] rdata_a, rdata_b;

  // An operation transfers when it is valid and the result stage has room.
  assign accept = in_valid_i && !in_stall_o;

  // Pointer and count state, decode and addresses for the memory.
  deq_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .kind_i     (kind_i),
    .value_i    (value_i),
    .position_i (position_i),
    .mem_req_o  (mem_req),
    .res_ctrl_o (res_ctrl)
  );

  // Element storage; the read data registers hold while no operation is taken.
  deq_store u_store (
    .clk_i     (clk_i),
    .re_i      (accept),
    .req_i     (mem_req),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  // Result assembly and the output register. Reads keep the cached head and
  // tail words, since a read changes neither end of the queue.
  deq_result u_result (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .res_ctrl_i    (res_ctrl),
    .rdata_a_i     (rdata_a),
    .rdata_b_i     (rdata_b),
    .out_stall_i   (out_stall_i),
    .in_stall_o    (in_stall_o),
    .out_valid_o   (out_valid_o),
    .front_value_o (front_value_o),
    .rear_value_o  (rear_value_o),
    .count_o       (count_o),
    .read_value_o  (read_value_o),
    .status_o      (status_o)
  );

endmodule

// ===== sv/deq_checker.sv =====
// Port-level assertions for the double-ended queue, bound to its top level.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module deq_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_stall_o,
  input logic [2:0]                  kind_i,
  input logic signed [31:0]          value_i,
  input logic [deq_pkg::POS_W-1:0]   position_i,
  input logic                        out_valid_o,
  input logic                        out_stall_i,
  input logic signed [31:0]          front_value_o,
  input logic signed [31:0]          rear_value_o,
  input logic [deq_pkg::COUNT_W-1:0] count_o,
  input logic signed [31:0]          read_value_o,
  input logic [1:0]                  status_o
);

  // A rejected push is only reported when the queue really is full.
  `DEQ_ASSERT(a_full_count, clk_i, rst_ni, (out_valid_o && status_o == deq_pkg::STATUS_PUSH_FULL) |-> (count_o == deq_pkg::COUNT_W'(deq_pkg::DEPTH)))

  // A rejected pop is only reported on an empty queue.
  `DEQ_ASSERT(a_empty_pop, clk_i, rst_ni, (out_valid_o && status_o == deq_pkg::STATUS_POP_EMPTY) |-> (count_o == '0))

  // An empty queue shows zero at both ends and cannot have served a read.
  `DEQ_ASSERT(a_empty_ends, clk_i, rst_ni, (out_valid_o && count_o == '0) |-> (front_value_o == '0 && rear_value_o == '0 && read_value_o == '0))

  // A stalled result stays offered and unchanged.
  `DEQ_ASSERT(a_out_hold, clk_i, rst_ni, (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(count_o) && $stable(front_value_o) && $stable(status_o)))

  // No result is offered while reset is applied.
  `DEQ_ASSERT_ALWAYS(a_reset_quiet, clk_i, !rst_ni |-> !out_valid_o)

endmodule

bind double_ended_queue deq_checker u_deq_checker (.*);
